// ----- rtl/cbez_pkg.sv -----
// ----------------------------------------------------------------------------
// cbez_pkg: shared types and constants of the cubic Bezier point evaluator
// Fixed point formats, control point register map and pipeline side-band.
// ----------------------------------------------------------------------------
package cbez_pkg;

  // coordinate and parameter formats
  localparam int COORD_W   = 16;            // signed Q2.14
  localparam int T_W       = 16;            // unsigned Q1.15
  localparam int FRAC_BITS = 15;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int SHIFT_W   = PROD_W - FRAC_BITS;

  localparam logic [T_W-1:0] T_ONE = T_W'(32768);
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(16384);

  // register map
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W = REG_IDX_W + 2;
  localparam int DATA_W = 32;
  localparam int MAX_POINTS = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [T_W-1:0] param_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // reset values of p0_x, p0_y .. p3_x, p3_y
  localparam coord_t REG_RESET [NUM_REGS] = '{
    -16'sd16384, 16'sd0, -16'sd4915, 16'sd8192,
    16'sd11469, -16'sd8192, 16'sd16384, 16'sd0
  };

  // side-band that travels with each transaction down the pipeline
  typedef struct packed {
    logic   valid;
    param_t t;
  } ctl_t;

endpackage

// ----- rtl/cbez_lerp.sv -----
// ----------------------------------------------------------------------------
// cbez_lerp: one De Casteljau interpolation level
// Two register stages: difference times t, then round, shift and add.
// ----------------------------------------------------------------------------
module cbez_lerp #(
  parameter int NUM_IN = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  cbez_pkg::ctl_t                        ctl_in,
  input  cbez_pkg::coord_t [NUM_IN-1:0]         x_in,
  input  cbez_pkg::coord_t [NUM_IN-1:0]         y_in,
  output cbez_pkg::ctl_t                        ctl_out,
  output cbez_pkg::coord_t [NUM_IN-2:0]         x_out,
  output cbez_pkg::coord_t [NUM_IN-2:0]         y_out
);

  localparam int NUM_OUT = NUM_IN - 1;

  cbez_pkg::ctl_t   ctl_a;
  cbez_pkg::coord_t base_x [NUM_OUT];
  cbez_pkg::coord_t base_y [NUM_OUT];
  cbez_pkg::prod_t  prod_x [NUM_OUT];
  cbez_pkg::prod_t  prod_y [NUM_OUT];
  cbez_pkg::prod_t  prod_x_next [NUM_OUT];
  cbez_pkg::prod_t  prod_y_next [NUM_OUT];
  cbez_pkg::coord_t res_x_next [NUM_OUT];
  cbez_pkg::coord_t res_y_next [NUM_OUT];

  // stage a: (b - a) * t for each neighbor pair
  always_comb begin
    logic signed [cbez_pkg::DIFF_W-1:0] t_s;
    logic signed [cbez_pkg::DIFF_W-1:0] dx;
    logic signed [cbez_pkg::DIFF_W-1:0] dy;
    t_s = $signed({1'b0, ctl_in.t});
    for (int j = 0; j < NUM_OUT; j++) begin
      dx = $signed({x_in[j+1][cbez_pkg::COORD_W-1], x_in[j+1]})
         - $signed({x_in[j][cbez_pkg::COORD_W-1], x_in[j]});
      dy = $signed({y_in[j+1][cbez_pkg::COORD_W-1], y_in[j+1]})
         - $signed({y_in[j][cbez_pkg::COORD_W-1], y_in[j]});
      prod_x_next[j] = dx * t_s;
      prod_y_next[j] = dy * t_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid <= 1'b0;
    end else if (adv) begin
      ctl_a.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_a.t <= ctl_in.t;
      for (int j = 0; j < NUM_OUT; j++) begin
        base_x[j] <= x_in[j];
        base_y[j] <= y_in[j];
        prod_x[j] <= prod_x_next[j];
        prod_y[j] <= prod_y_next[j];
      end
    end
  end

  // stage b: round half up, floor shift and add to the base point
  always_comb begin
    cbez_pkg::prod_t sx;
    cbez_pkg::prod_t sy;
    logic signed [cbez_pkg::SHIFT_W-1:0] ax;
    logic signed [cbez_pkg::SHIFT_W-1:0] ay;
    for (int j = 0; j < NUM_OUT; j++) begin
      sx = (prod_x[j] + cbez_pkg::ROUND_BIAS) >>> cbez_pkg::FRAC_BITS;
      sy = (prod_y[j] + cbez_pkg::ROUND_BIAS) >>> cbez_pkg::FRAC_BITS;
      ax = cbez_pkg::SHIFT_W'(base_x[j]) + sx[cbez_pkg::SHIFT_W-1:0];
      ay = cbez_pkg::SHIFT_W'(base_y[j]) + sy[cbez_pkg::SHIFT_W-1:0];
      res_x_next[j] = ax[cbez_pkg::COORD_W-1:0];
      res_y_next[j] = ay[cbez_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (adv) begin
      ctl_out.valid <= ctl_a.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_out.t <= ctl_a.t;
      for (int j = 0; j < NUM_OUT; j++) begin
        x_out[j] <= res_x_next[j];
        y_out[j] <= res_y_next[j];
      end
    end
  end

endmodule

// ----- rtl/cubic_bezier_point_eval_top.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_top: Bezier curve point evaluator
// Evaluates a 2-D Bezier curve at t by pipelined De Casteljau interpolation.
// ----------------------------------------------------------------------------
// Usage:
// - control points p0..p3 (x, y, signed Q2.14) sit in APB registers at byte
//   addresses 0x00..0x1c; write them while no transaction is in flight
// - input channel: param_valid / param_stall carry curve_param (t, Q1.15);
//   t above 1.0 is clamped to 1.0
// - output channel: point_valid / point_stall carry point_x, point_y
// - pipeline: one input stage plus a multiply stage and an add stage per
//   interpolation level; two multipliers (x, y) per lerp per level
// - throughput: one transaction per cycle while point_stall does not hold it
// - a stalled result holds the whole pipeline; param_stall rises in the same
//   cycle, so nothing is lost or repeated
// - reset empties the pipeline and loads the default control points
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval_top #(
  parameter int NUM_CONTROL_POINTS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  // input transaction
  input  logic                          param_valid,
  output logic                          param_stall,
  input  logic [15:0]                   curve_param,
  // output transaction
  output logic                          point_valid,
  input  logic                          point_stall,
  output logic signed [15:0]            point_x,
  output logic signed [15:0]            point_y,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbez_pkg::ADDR_W-1:0]   paddr,
  input  logic [cbez_pkg::DATA_W-1:0]   pwdata,
  output logic [cbez_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int N = NUM_CONTROL_POINTS;

  cbez_pkg::coord_t regs [cbez_pkg::NUM_REGS];
  logic [cbez_pkg::REG_IDX_W-1:0] reg_idx;
  logic adv;
  cbez_pkg::param_t t_sat;

  cbez_pkg::ctl_t                    chain_ctl [N];
  cbez_pkg::coord_t [N-1:0]          chain_x   [N];
  cbez_pkg::coord_t [N-1:0]          chain_y   [N];

  // configuration registers
  assign reg_idx = paddr[cbez_pkg::ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = cbez_pkg::DATA_W'(regs[reg_idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= cbez_pkg::REG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      regs[reg_idx] <= pwdata[cbez_pkg::COORD_W-1:0];
    end
  end

  // global pipeline advance
  assign adv         = !(point_valid && point_stall);
  assign param_stall = !adv;

  // input stage with clamp of t to 1.0
  assign t_sat = (curve_param > cbez_pkg::T_ONE) ? cbez_pkg::T_ONE : curve_param;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_ctl[0].valid <= 1'b0;
    end else if (adv) begin
      chain_ctl[0].valid <= param_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chain_ctl[0].t <= t_sat;
    end
  end

  // control points feed the first level
  always_comb begin
    for (int i = 0; i < N; i++) begin
      chain_x[0][i] = regs[2*i];
      chain_y[0][i] = regs[2*i+1];
    end
  end

  // interpolation levels
  for (genvar k = 1; k < N; k++) begin : g_level
    cbez_lerp #(
      .NUM_IN (N - k + 1)
    ) u_lerp (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .ctl_in  (chain_ctl[k-1]),
      .x_in    (chain_x[k-1][N-k:0]),
      .y_in    (chain_y[k-1][N-k:0]),
      .ctl_out (chain_ctl[k]),
      .x_out   (chain_x[k][N-k-1:0]),
      .y_out   (chain_y[k][N-k-1:0])
    );
    assign chain_x[k][N-1:N-k] = '0;
    assign chain_y[k][N-1:N-k] = '0;
  end

  // result
  assign point_valid = chain_ctl[N-1].valid;
  assign point_x     = chain_x[N-1][0];
  assign point_y     = chain_y[N-1][0];

endmodule
